[hw/rtl/knn_pkg.sv]
package knn_pkg;

  localparam int TOP_K    = 30;
  localparam int FEATURES = 784;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 8;
  localparam int FIDX_W  = 10;
  localparam int ID_W    = 14;
  localparam int DIST_W  = 32;
  localparam int RANK_W  = 5;
  localparam int SQ_W    = 2 * VALUE_W;

  localparam int ADDR_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int POS_W  = $clog2(FEATURES + 1);
  localparam int IDX_W  = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  localparam logic [DIST_W-1:0] SENTINEL = '1;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REF    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_INS,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic ins;
    logic clr;
  } list_ctl_t;

endpackage

[hw/rtl/knn_list.sv]
module knn_list (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  knn_pkg::list_ctl_t          ctl_i,
  input  logic [knn_pkg::IDX_W-1:0]   idx_i,
  input  logic [knn_pkg::DIST_W-1:0]  carry_dist_i,
  input  logic [knn_pkg::ID_W-1:0]    carry_id_i,
  output logic [knn_pkg::DIST_W-1:0]  ent_dist_o,
  output logic [knn_pkg::ID_W-1:0]    ent_id_o,
  output logic                        swap_o
);

  logic [knn_pkg::DIST_W-1:0] dist_q [knn_pkg::TOP_K];
  logic [knn_pkg::ID_W-1:0]   id_q   [knn_pkg::TOP_K];

  assign ent_dist_o = dist_q[idx_i];
  assign ent_id_o   = id_q[idx_i];
  assign swap_o     = carry_dist_i < ent_dist_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < knn_pkg::TOP_K; i++) begin
        dist_q[i] <= knn_pkg::SENTINEL;
        id_q[i]   <= '0;
      end
    end else if (ctl_i.clr) begin
      dist_q[idx_i] <= knn_pkg::SENTINEL;
      id_q[idx_i]   <= '0;
    end else if (ctl_i.ins && swap_o) begin
      dist_q[idx_i] <= carry_dist_i;
      id_q[idx_i]   <= carry_id_i;
    end
  end

endmodule

[hw/rtl/knn_top_k_search.sv]
// Query load: a new word every cycle.
// Reference word: square (ST_MUL) then accumulate (ST_ACC); a point's last word, unless
// skipped, adds list insertion over all TOP_K entries, one entry per cycle through a single shared compare unit.
// Finish: the word starts ST_EMIT, which registers one result per cycle while not stalled;
// TOP_K results in all, the list clearing entry by entry as it drains.
// Reset clears the list, accumulator, counters and query id, not the query feature memory.
module knn_top_k_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [knn_pkg::CMD_W-1:0]     command_i,
  input  logic [knn_pkg::VALUE_W-1:0]   value_i,
  input  logic [knn_pkg::FIDX_W-1:0]    feature_index_i,
  input  logic [knn_pkg::ID_W-1:0]      point_id_i,
  input  logic                          last_feature_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [knn_pkg::RANK_W-1:0]    rank_o,
  output logic [knn_pkg::DIST_W-1:0]    distance_o,
  output logic [knn_pkg::ID_W-1:0]      neighbor_id_o,
  output logic                          filled_o,
  output logic                          last_o
);

  knn_pkg::state_e state_q, state_d;

  logic [knn_pkg::VALUE_W-1:0] qmem [knn_pkg::FEATURES];
  logic [knn_pkg::VALUE_W-1:0] rd_q;

  logic [knn_pkg::POS_W-1:0]   elem_pos_q, elem_pos_d;
  logic [knn_pkg::DIST_W-1:0]  acc_q, acc_d;
  logic [knn_pkg::ID_W-1:0]    qid_q, qid_d;
  logic [knn_pkg::VALUE_W-1:0] val_q, val_d;
  logic [knn_pkg::ID_W-1:0]    pid_q, pid_d;
  logic                        lastf_q, lastf_d;
  logic                        inrng_q, inrng_d;
  logic [knn_pkg::SQ_W-1:0]    sq_q, sq_d;
  logic [knn_pkg::DIST_W-1:0]  carry_dist_q, carry_dist_d;
  logic [knn_pkg::ID_W-1:0]    carry_id_q, carry_id_d;
  logic [knn_pkg::IDX_W-1:0]   idx_q, idx_d;

  logic                        out_valid_q, out_valid_d;
  logic [knn_pkg::RANK_W-1:0]  rank_q, rank_d;
  logic [knn_pkg::DIST_W-1:0]  dist_q, dist_d;
  logic [knn_pkg::ID_W-1:0]    nid_q, nid_d;
  logic                        filled_q, filled_d;
  logic                        last_q, last_d;

  knn_pkg::list_ctl_t          list_ctl;
  logic [knn_pkg::DIST_W-1:0]  ent_dist;
  logic [knn_pkg::ID_W-1:0]    ent_id;
  logic                        swap;

  logic                        in_acc;
  logic                        out_free;
  logic                        qwr;
  logic [knn_pkg::VALUE_W-1:0] diff;
  logic [knn_pkg::DIST_W:0]    sum;
  logic [knn_pkg::DIST_W-1:0]  acc_new;
  logic                        idx_end;
  logic                        ent_filled;

  assign in_stall_o = (state_q != knn_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign qwr        = in_acc && (command_i == knn_pkg::CMD_LOAD) &&
                      (32'(feature_index_i) < knn_pkg::FEATURES);

  assign diff    = (rd_q > val_q) ? (rd_q - val_q) : (val_q - rd_q);
  assign sum     = {1'b0, acc_q} + (knn_pkg::DIST_W + 1)'(sq_q);
  assign acc_new = sum[knn_pkg::DIST_W] ? knn_pkg::SENTINEL : sum[knn_pkg::DIST_W-1:0];
  assign idx_end = (idx_q == knn_pkg::IDX_W'(knn_pkg::TOP_K - 1));
  assign ent_filled = (ent_dist != knn_pkg::SENTINEL);

  always_ff @(posedge clk_i) begin
    if (qwr) begin
      qmem[knn_pkg::ADDR_W'(feature_index_i)] <= value_i;
    end
    rd_q <= qmem[elem_pos_q[knn_pkg::ADDR_W-1:0]];
  end

  knn_list u_list (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (list_ctl),
    .idx_i        (idx_q),
    .carry_dist_i (carry_dist_q),
    .carry_id_i   (carry_id_q),
    .ent_dist_o   (ent_dist),
    .ent_id_o     (ent_id),
    .swap_o       (swap)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= knn_pkg::ST_IDLE;
      elem_pos_q  <= '0;
      acc_q       <= '0;
      qid_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elem_pos_q  <= elem_pos_d;
      acc_q       <= acc_d;
      qid_q       <= qid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    pid_q        <= pid_d;
    lastf_q      <= lastf_d;
    inrng_q      <= inrng_d;
    sq_q         <= sq_d;
    carry_dist_q <= carry_dist_d;
    carry_id_q   <= carry_id_d;
    rank_q       <= rank_d;
    dist_q       <= dist_d;
    nid_q        <= nid_d;
    filled_q     <= filled_d;
    last_q       <= last_d;
  end

  always_comb begin
    state_d      = state_q;
    elem_pos_d   = elem_pos_q;
    acc_d        = acc_q;
    qid_d        = qid_q;
    val_d        = val_q;
    pid_d        = pid_q;
    lastf_d      = lastf_q;
    inrng_d      = inrng_q;
    sq_d         = sq_q;
    carry_dist_d = carry_dist_q;
    carry_id_d   = carry_id_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    rank_d       = rank_q;
    dist_d       = dist_q;
    nid_d        = nid_q;
    filled_d     = filled_q;
    last_d       = last_q;
    list_ctl     = '0;

    case (state_q)
      knn_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (command_i)
            knn_pkg::CMD_LOAD: begin
              qid_d = point_id_i;
            end
            knn_pkg::CMD_REF: begin
              val_d   = value_i;
              pid_d   = point_id_i;
              lastf_d = last_feature_i;
              inrng_d = (elem_pos_q < knn_pkg::POS_W'(knn_pkg::FEATURES));
              if (inrng_d) begin
                elem_pos_d = elem_pos_q + 1'b1;
              end
              state_d = knn_pkg::ST_MUL;
            end
            knn_pkg::CMD_FINISH: begin
              acc_d      = '0;
              elem_pos_d = '0;
              idx_d      = '0;
              state_d    = knn_pkg::ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      knn_pkg::ST_MUL: begin
        sq_d    = inrng_q ? (knn_pkg::SQ_W'(diff) * knn_pkg::SQ_W'(diff)) : '0;
        state_d = knn_pkg::ST_ACC;
      end
      knn_pkg::ST_ACC: begin
        acc_d   = acc_new;
        state_d = knn_pkg::ST_IDLE;
        if (lastf_q) begin
          acc_d      = '0;
          elem_pos_d = '0;
          if (pid_q != qid_q && acc_new != knn_pkg::SENTINEL) begin
            carry_dist_d = acc_new;
            carry_id_d   = pid_q;
            idx_d        = '0;
            state_d      = knn_pkg::ST_INS;
          end
        end
      end
      knn_pkg::ST_INS: begin
        list_ctl.ins = 1'b1;
        if (swap) begin
          carry_dist_d = ent_dist;
          carry_id_d   = ent_id;
        end
        idx_d = idx_q + 1'b1;
        if (idx_end) begin
          state_d = knn_pkg::ST_IDLE;
        end
      end
      knn_pkg::ST_EMIT: begin
        if (out_free) begin
          list_ctl.clr = 1'b1;
          out_valid_d  = 1'b1;
          rank_d       = knn_pkg::RANK_W'(idx_q);
          dist_d       = ent_dist;
          nid_d        = ent_filled ? ent_id : '0;
          filled_d     = ent_filled;
          last_d       = idx_end;
          idx_d        = idx_q + 1'b1;
          if (idx_end) begin
            state_d = knn_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = knn_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign rank_o        = rank_q;
  assign distance_o    = dist_q;
  assign neighbor_id_o = nid_q;
  assign filled_o      = filled_q;
  assign last_o        = last_q;

  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && command_i == knn_pkg::CMD_FINISH |=> state_q == knn_pkg::ST_EMIT)
    else $error("finish word did not start emission");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == knn_pkg::ST_EMIT))
    else $error("result appeared outside emission");

  a_last_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> rank_o == knn_pkg::RANK_W'(knn_pkg::TOP_K - 1))
    else $error("last result at wrong rank");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_pos_q <= knn_pkg::POS_W'(knn_pkg::FEATURES))
    else $error("element position beyond feature count");

endmodule

[sim/tb_knn_top_k_search.sv]
module tb_knn_top_k_search;
  timeunit 1ns;
  timeprecision 1ps;

  import knn_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_WORDS   = 150;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [DIST_W-1:0] distance;
    logic [ID_W-1:0]   nbr_id;
    logic              filled;
    logic              is_last;
  } ranked_t;

  typedef enum {VAL_RANDOM, VAL_MATCH, VAL_FAR} fill_mode_e;

  class neighbor_ranker;
    logic [VALUE_W-1:0] qfeat [FEATURES];
    logic [ID_W-1:0]    qid;
    logic [DIST_W-1:0]  acc;
    int unsigned        pos;
    logic [DIST_W-1:0]  best_d [TOP_K];
    logic [ID_W-1:0]    best_id [TOP_K];
    ranked_t            pending [$];
    int unsigned        errors;
    int unsigned        results;
    int unsigned        finishes;
    int unsigned        self_skips;

    function new();
      foreach (qfeat[i]) qfeat[i] = '0;
      qid        = '0;
      acc        = '0;
      pos        = 0;
      errors     = 0;
      results    = 0;
      finishes   = 0;
      self_skips = 0;
      clear_list();
    endfunction

    function void clear_list();
      foreach (best_d[i]) begin
        best_d[i]  = SENTINEL;
        best_id[i] = '0;
      end
    endfunction

    function void insert(logic [DIST_W-1:0] d, logic [ID_W-1:0] id);
      logic [DIST_W-1:0] td;
      logic [ID_W-1:0]   ti;
      if (d > best_d[TOP_K-1]) return;
      for (int l = 0; l < TOP_K; l++) begin
        if (d < best_d[l]) begin
          td         = best_d[l];
          ti         = best_id[l];
          best_d[l]  = d;
          best_id[l] = id;
          d          = td;
          id         = ti;
        end
      end
    endfunction

    function void take_word(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val,
                            logic [FIDX_W-1:0] fidx, logic [ID_W-1:0] pid, logic lastf);
      logic [DIST_W-1:0] q;
      logic [DIST_W-1:0] v;
      logic [DIST_W-1:0] diff;
      logic [DIST_W-1:0] sq;
      ranked_t           r;
      case (cmd)
        CMD_LOAD: begin
          qid = pid;
          if (fidx < FEATURES) qfeat[fidx] = val;
        end
        CMD_REF: begin
          if (pos < FEATURES) begin
            q    = {{(DIST_W-VALUE_W){1'b0}}, qfeat[pos]};
            v    = {{(DIST_W-VALUE_W){1'b0}}, val};
            diff = (q > v) ? q - v : v - q;
            sq   = diff * diff;
            acc  = (acc > SENTINEL - sq) ? SENTINEL : acc + sq;
            pos++;
          end
          if (lastf) begin
            if (pid == qid) self_skips++;
            else if (acc != SENTINEL) insert(acc, pid);
            acc = '0;
            pos = 0;
          end
        end
        CMD_FINISH: begin
          for (int k = 0; k < TOP_K; k++) begin
            r.rank     = k[RANK_W-1:0];
            r.distance = best_d[k];
            r.filled   = (best_d[k] != SENTINEL);
            r.nbr_id   = r.filled ? best_id[k] : '0;
            r.is_last  = (k == TOP_K - 1);
            pending.push_back(r);
          end
          clear_list();
          acc = '0;
          pos = 0;
          finishes++;
        end
        default: ;
      endcase
    endfunction

    function void flag(string field, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_ranked(ranked_t got);
      ranked_t want;
      results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, rank %0d distance %0d id %0d",
                   $time, got.rank, got.distance, got.nbr_id);
        return;
      end
      want = pending.pop_front();
      if (got.rank !== want.rank)
        flag("rank", DIST_W'(want.rank), DIST_W'(got.rank));
      if (got.distance !== want.distance)
        flag("distance", want.distance, got.distance);
      if (got.nbr_id !== want.nbr_id)
        flag("neighbor_id", DIST_W'(want.nbr_id), DIST_W'(got.nbr_id));
      if (got.filled !== want.filled)
        flag("filled", DIST_W'(want.filled), DIST_W'(got.filled));
      if (got.is_last !== want.is_last)
        flag("last", DIST_W'(want.is_last), DIST_W'(got.is_last));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i       = '0;
  logic [VALUE_W-1:0]   value_i         = '0;
  logic [FIDX_W-1:0]    feature_index_i = '0;
  logic [ID_W-1:0]      point_id_i      = '0;
  logic                 last_feature_i  = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [RANK_W-1:0]    rank_o;
  logic [DIST_W-1:0]    distance_o;
  logic [ID_W-1:0]      neighbor_id_o;
  logic                 filled_o;
  logic                 last_o;

  neighbor_ranker ranker = new();

  bit qwritten [FEATURES];
  int prefix     = 0;
  int send_idle  = 0;
  int recv_stall = 0;
  int words      = 0;
  int idle_cycles = 0;
  int idle_pct  [4] = '{0, 85, 0, 14};
  int stall_pct [4] = '{0, 0, 85, 14};

  knn_top_k_search DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .value_i         (value_i),
    .feature_index_i (feature_index_i),
    .point_id_i      (point_id_i),
    .last_feature_i  (last_feature_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .rank_o          (rank_o),
    .distance_o      (distance_o),
    .neighbor_id_o   (neighbor_id_o),
    .filled_o        (filled_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      ranker.check_ranked('{rank_o, distance_o, neighbor_id_o, filled_o, last_o});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("knn_top_k_search test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val,
                           logic [FIDX_W-1:0] fidx, logic [ID_W-1:0] pid, logic lastf);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    value_i         <= val;
    feature_index_i <= fidx;
    point_id_i      <= pid;
    last_feature_i  <= lastf;
    do @(posedge clk_i); while (in_stall_o);
    ranker.take_word(cmd, val, fidx, pid, lastf);
    if (cmd != CMD_UNUSED) words++;
    if (cmd == CMD_LOAD && fidx < FEATURES) begin
      qwritten[fidx] = 1'b1;
      while (prefix < FEATURES && qwritten[prefix]) prefix++;
    end
  endtask

  // keep every reference word paired with a written query feature
  task automatic send_point(int len, logic [ID_W-1:0] pid, fill_mode_e mode, bit complete);
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] v;
    int                 room;
    room = prefix - int'(ranker.pos) - (complete ? 0 : 1);
    if (prefix < FEATURES && len > room) len = room;
    for (int i = 0; i < len; i++) begin
      q = (ranker.pos < FEATURES) ? ranker.qfeat[ranker.pos] : '0;
      case (mode)
        VAL_MATCH: v = q;
        VAL_FAR:   v = q[VALUE_W-1] ? '0 : '1;
        default:   v = VALUE_W'($urandom_range(255));
      endcase
      send_word(CMD_REF, v, FIDX_W'($urandom_range(1023)),
                (i == len - 1) ? pid : ID_W'($urandom_range(16383)),
                complete && (i == len - 1));
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ranker.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int               npts;
    int               pick;
    int               phase_end;
    bit               big;
    fill_mode_e       mode;
    logic [ID_W-1:0]  pid;
    logic [FIDX_W-1:0] idx;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_FINISH, '0, '0, '0, 1'b0);
    send_word(CMD_UNUSED, '1, '1, '1, 1'b1);
    send_word(CMD_LOAD, 8'd0, 10'd0, 14'd5, 1'b0);
    send_word(CMD_LOAD, 8'd255, 10'd1, 14'd5, 1'b0);
    send_word(CMD_LOAD, 8'd128, 10'd2, 14'd5, 1'b0);
    send_word(CMD_LOAD, 8'd1, 10'd3, 14'd5, 1'b0);
    send_word(CMD_LOAD, 8'd77, 10'd1023, 14'd9, 1'b1);
    send_word(CMD_LOAD, 8'd66, FIDX_W'(FEATURES), 14'd9, 1'b0);
    send_point(2, 14'd9, VAL_RANDOM, 1'b1);
    send_point(4, 14'h3FFF, VAL_MATCH, 1'b1);
    send_point(4, 14'd0, VAL_MATCH, 1'b1);
    send_point(4, 14'd100, VAL_FAR, 1'b1);
    send_point(1, 14'd3, VAL_RANDOM, 1'b1);
    send_word(CMD_FINISH, '0, '0, '0, 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = idle_pct[ph];
      recv_stall = stall_pct[ph];
      phase_end  = words + RANDOM_WORDS / 4;
      while (words < phase_end) begin
        big  = (ph == 0) || ($urandom_range(7) == 0);
        npts = big ? $urandom_range(30, 36) : $urandom_range(8);
        for (int p = 0; p < npts; p++) begin
          pick = $urandom_range(99);
          if (pick < 8) begin
            idx = ($urandom_range(9) < 7) ? FIDX_W'($urandom_range(prefix)) :
                                            FIDX_W'($urandom_range(1023));
            pid = $urandom_range(1) ? ranker.qid : ID_W'($urandom_range(16383));
            send_word(CMD_LOAD, VALUE_W'($urandom_range(255)), idx, pid,
                      1'($urandom_range(1)));
          end else if (pick < 11) begin
            send_word(CMD_UNUSED, VALUE_W'($urandom_range(255)),
                      FIDX_W'($urandom_range(1023)), ID_W'($urandom_range(16383)),
                      1'($urandom_range(1)));
          end else if (pick < 17) begin
            send_point($urandom_range(1, 3), ID_W'($urandom_range(16383)), VAL_RANDOM, 1'b0);
          end else begin
            pid  = ($urandom_range(9) == 0) ? ranker.qid : ID_W'($urandom_range(16383));
            pick = $urandom_range(9);
            mode = (pick == 0) ? VAL_MATCH : (pick == 1) ? VAL_FAR : VAL_RANDOM;
            send_point($urandom_range(1, 3), pid, mode, 1'b1);
          end
        end
        if ($urandom_range(3) == 0)
          send_point(2, ID_W'($urandom_range(16383)), VAL_RANDOM, 1'b0);
        send_word(CMD_FINISH, VALUE_W'($urandom_range(255)), FIDX_W'($urandom_range(1023)),
                  ID_W'($urandom_range(16383)), 1'($urandom_range(1)));
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d input words and %0d finishes (%0d self matches skipped),",
             words, ranker.finishes, ranker.self_skips);
    $display("with %0d ranked results checked across four handshake pressure phases",
             ranker.results);
    if (ranker.errors == 0 && ranker.pending.size() == 0) begin
      $display("knn_top_k_search test passed");
    end else begin
      $display("knn_top_k_search test failed");
    end
    $finish;
  end

endmodule
